[src/spq_pkg.sv]
// Shared types and constants for the stable priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   localparam int LOCATION_BITS = 16;
   localparam int TYPE_BITS     = 8;
   localparam int URGENCY_BITS  = 4;
   localparam int STATUS_BITS   = 3;
   localparam int OCC_BITS      = 5;

   localparam logic [URGENCY_BITS-1:0] URG_MIN = URGENCY_BITS'(1);
   localparam logic [URGENCY_BITS-1:0] URG_MAX = URGENCY_BITS'(10);

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_REMOVE = 1'b1
   } func_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK      = 3'd0,
      ST_NOTAG   = 3'd1,
      ST_URGENCY = 3'd2,
      ST_EMPTY   = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   typedef struct packed {
      func_type                 func;
      logic [LOCATION_BITS-1:0] location_tag;
      logic [TYPE_BITS-1:0]     type_tag;
      logic [URGENCY_BITS-1:0]  urgency;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic [LOCATION_BITS-1:0] out_location;
      logic [TYPE_BITS-1:0]     out_type;
      logic [URGENCY_BITS-1:0]  out_urgency;
      logic [OCC_BITS-1:0]      occupancy;
   } rsp_type;

   typedef struct packed {
      logic [LOCATION_BITS-1:0] loc;
      logic [TYPE_BITS-1:0]     typ;
      logic [URGENCY_BITS-1:0]  urg;
   } entry_type;

   // Broadcast from the top level to every cell in the chain.
   typedef struct packed {
      logic      insert;
      logic      pop;
      entry_type entry;
   } cell_cmd_type;

endpackage

`default_nettype wire

[src/spq_cell.sv]
// One storage cell of the sorted chain: holds a single entry and its valid bit.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
   import spq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_cmd_type cmd,
   input  wire entry_type    left_entry,
   input  wire logic         left_valid,
   input  wire logic         left_ge,
   input  wire entry_type    right_entry,
   input  wire logic         right_valid,
   output      entry_type    entry_out,
   output      logic         valid_out,
   output      logic         ge_out
);

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;
   logic      ge;

   // The entry stays ahead of a new one when its urgency is at least as high.
   assign ge = valid_ff && (entry_ff.urg >= cmd.entry.urg);

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (cmd.pop) begin
         entry_in = right_entry;
         valid_in = right_valid;
      end else if (cmd.insert && !ge) begin
         if (left_ge) begin
            entry_in = cmd.entry;
            valid_in = 1'b1;
         end else begin
            entry_in = left_entry;
            valid_in = left_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;
   assign valid_out = valid_ff;
   assign ge_out    = ge;

endmodule

`default_nettype wire

[src/stable_priority_queue.sv]
// Top level of the stable priority queue built as a chain of sorting cells.
`timescale 1ns / 1ps
`default_nettype none

// Bounded priority queue of requests kept in descending urgency order, with
// entries of equal urgency served first-in first-out.
//
// Input channel: a command transfer happens at a rising edge where start is
// high and busy is low. req_payload.func selects insert or remove.
// Result channel: every command gives exactly one result, shown on rsp_payload
// for one cycle while rsp_strobe is high, in the cycle right after the
// command transfer. The receiver cannot stall; results are never held.
//
// Throughput is one command per cycle while busy is low. Each cell compares
// its own urgency with the new entry in parallel, so a remove shifts the whole
// chain by one position and an insert shifts the cells behind the new entry.
//
// Reset clears every valid bit and the entry count; busy is high during reset
// and drops in the first cycle after it. Stored payloads are not cleared.
module stable_priority_queue
   import spq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output      logic    busy,
   input  wire req_type req_payload,
   output      logic    rsp_strobe,
   output      rsp_type rsp_payload
);

   localparam int CNT_BITS = $clog2(CAPACITY + 1);

   logic                  busy_ff;
   logic                  rsp_strobe_ff;
   rsp_type               rsp_ff, rsp_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [CNT_BITS+4:0]   occ_ext;

   cell_cmd_type          cmd;
   entry_type             cell_entry [CAPACITY];
   logic [CAPACITY-1:0]   cell_valid;
   logic [CAPACITY-1:0]   cell_ge;

   logic                  accept;
   logic                  is_insert;
   logic                  is_full;
   logic                  is_empty;
   status_type            status;

   assign accept    = start && !busy_ff;
   assign is_insert = (req_payload.func == FUNC_INSERT);
   assign is_full   = (count_ff == CNT_BITS'(CAPACITY));
   assign is_empty  = (count_ff == '0);

   // Remove checks emptiness; insert checks tags, then urgency, then room.
   always_comb begin
      if (!is_insert) begin
         status = is_empty ? ST_EMPTY : ST_OK;
      end else if (req_payload.location_tag == '0 || req_payload.type_tag == '0) begin
         status = ST_NOTAG;
      end else if (req_payload.urgency < URG_MIN || req_payload.urgency > URG_MAX) begin
         status = ST_URGENCY;
      end else if (is_full) begin
         status = ST_FULL;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      cmd.insert    = accept && is_insert && (status == ST_OK);
      cmd.pop       = accept && !is_insert && (status == ST_OK);
      cmd.entry.loc = req_payload.location_tag;
      cmd.entry.typ = req_payload.type_tag;
      cmd.entry.urg = req_payload.urgency;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   // The occupancy field reports the low bits of the count.
   assign occ_ext = {5'b0, count_in};

   always_comb begin
      rsp_in.status       = status;
      rsp_in.out_location = '0;
      rsp_in.out_type     = '0;
      rsp_in.out_urgency  = '0;
      rsp_in.occupancy    = occ_ext[OCC_BITS-1:0];
      if (cmd.pop) begin
         rsp_in.out_location = cell_entry[0].loc;
         rsp_in.out_type     = cell_entry[0].typ;
         rsp_in.out_urgency  = cell_entry[0].urg;
      end
   end

   // The head cell sees an always-ahead left neighbor; the tail cell sees an
   // empty right neighbor, so a remove shifts an empty slot in at the end.
   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         entry_type l_entry, r_entry;
         logic      l_valid, l_ge, r_valid;

         if (i == 0) begin : g_head
            assign l_entry = '0;
            assign l_valid = 1'b0;
            assign l_ge    = 1'b1;
         end else begin : g_mid
            assign l_entry = cell_entry[i-1];
            assign l_valid = cell_valid[i-1];
            assign l_ge    = cell_ge[i-1];
         end

         if (i == CAPACITY - 1) begin : g_tail
            assign r_entry = '0;
            assign r_valid = 1'b0;
         end else begin : g_body
            assign r_entry = cell_entry[i+1];
            assign r_valid = cell_valid[i+1];
         end

         spq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmd),
            .left_entry  (l_entry),
            .left_valid  (l_valid),
            .left_ge     (l_ge),
            .right_entry (r_entry),
            .right_valid (r_valid),
            .entry_out   (cell_entry[i]),
            .valid_out   (cell_valid[i]),
            .ge_out      (cell_ge[i])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         rsp_strobe_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= accept;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign busy        = busy_ff;
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // Valid cells always form an unbroken run from the head.
   a_valid_prefix : assert property (@(posedge clock) disable iff (reset)
      $onehot({1'b0, cell_valid} + (CAPACITY + 1)'(1)))
      else $error("valid cells are not a contiguous run from the head");

   // The entry count tracks the number of valid cells.
   a_count_match : assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count_ff))
      else $error("entry count disagrees with valid cells");

   // Every command transfer gives a result in the next cycle.
   a_one_result : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("command transfer without a result");

   // A successful remove returns an entry that was accepted with a valid urgency.
   a_pop_urgency : assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> (cell_entry[0].urg >= URG_MIN && cell_entry[0].urg <= URG_MAX))
      else $error("head entry holds an out-of-range urgency");
`endif

endmodule

`default_nettype wire
